### hw/rtl/rmr_pkg.sv
// Package: types and constants shared by the rational multiply-reduce block.
`timescale 1ns / 1ps
package rmr_pkg;
	localparam int OPERAND_WIDTH = 32;
	localparam int MAG_WIDTH     = 63;
	localparam int CNT_WIDTH     = 7;

	typedef struct packed {
		logic signed [31:0] left_numerator;
		logic signed [31:0] left_denominator;
		logic signed [31:0] right_numerator;
		logic signed [31:0] right_denominator;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] product_numerator;
		logic signed [63:0] product_denominator;
		logic               zero_over_zero;
	} out_item_t;

	// Work item handed from the front end to the back end.
	typedef struct packed {
		logic                 num_neg;
		logic                 den_neg;
		logic [MAG_WIDTH-1:0] num_mag;
		logic [MAG_WIDTH-1:0] den_mag;
	} work_t;

	// Sign-extend the low OPERAND_WIDTH bits of a field to 33 bits.
	function automatic logic signed [32:0] sext_op(input logic [31:0] v);
		logic [OPERAND_WIDTH-1:0] low;
		low = v[OPERAND_WIDTH-1:0];
		return 33'(signed'(low));
	endfunction
endpackage

### hw/rtl/rmr_front.sv
// Front end: accepts an item, forms both products, splits them into sign and magnitude.
`timescale 1ns / 1ps
module rmr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rmr_pkg::in_item_t in_item,
	output logic             wvalid,
	input  logic             wready,
	output rmr_pkg::work_t   work
);
	logic                 in_vld_s1;
	logic signed [32:0]   ln_s1, ld_s1, rn_s1, rd_s1;
	logic                 vld_s2;
	logic signed [65:0]   pn_s2, pd_s2;
	logic                 adv_s2;

	assign adv_s2 = !vld_s2 || wready;
	assign full   = in_vld_s1 && !adv_s2;

	// Stage 1: operand capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (!full) begin
			in_vld_s1 <= push;
		end
	end
	always_ff @(posedge clk) begin
		if (push && !full) begin
			ln_s1 <= rmr_pkg::sext_op(in_item.left_numerator);
			ld_s1 <= rmr_pkg::sext_op(in_item.left_denominator);
			rn_s1 <= rmr_pkg::sext_op(in_item.right_numerator);
			rd_s1 <= rmr_pkg::sext_op(in_item.right_denominator);
		end
	end

	// Stage 2: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= in_vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s2 && in_vld_s1) begin
			pn_s2 <= ln_s1 * rn_s1;
			pd_s2 <= ld_s1 * rd_s1;
		end
	end

	logic [65:0] pn_abs, pd_abs;
	assign pn_abs = pn_s2[65] ? 66'(-pn_s2) : pn_s2;
	assign pd_abs = pd_s2[65] ? 66'(-pd_s2) : pd_s2;

	assign wvalid       = vld_s2;
	assign work.num_neg = pn_s2[65];
	assign work.den_neg = pd_s2[65];
	assign work.num_mag = pn_abs[rmr_pkg::MAG_WIDTH-1:0];
	assign work.den_mag = pd_abs[rmr_pkg::MAG_WIDTH-1:0];
endmodule

### hw/rtl/rmr_queue.sv
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
module rmr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wvalid,
	output logic           wready,
	input  rmr_pkg::work_t wdata,
	output logic           rvalid,
	input  logic           rready,
	output rmr_pkg::work_t rdata
);
	rmr_pkg::work_t mem_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     cnt_q;
	logic           wr, rd;

	assign wready = (cnt_q != 2'd2);
	assign rvalid = (cnt_q != 2'd0);
	assign wr     = wvalid && wready;
	assign rd     = rvalid && rready;
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr) wptr_q <= !wptr_q;
			if (rd) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wdata;
	end
endmodule

### hw/rtl/rmr_back.sv
// Back end: Euclidean GCD by restoring remainder, then two exact divisions.
`timescale 1ns / 1ps
module rmr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rvalid,
	output logic              rready,
	input  rmr_pkg::work_t    work,
	output logic              empty,
	input  logic              pop,
	output rmr_pkg::out_item_t out_item
);
	localparam int W = rmr_pkg::MAG_WIDTH;
	localparam int C = rmr_pkg::CNT_WIDTH;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_GCD  = 6'b000010,
		ST_DIVN = 6'b000100,
		ST_DIVD = 6'b001000,
		ST_DONE = 6'b010000,
		ST_MOD  = 6'b100000
	} state_t;

	state_t         state_q;
	logic           nneg_q, dneg_q;
	logic [W-1:0]   nmag_q, dmag_q;
	logic [W-1:0]   a_q, b_q;
	logic [W-1:0]   rem_q, quo_q, dvd_q;
	logic [C-1:0]   cnt_q;
	logic [W-1:0]   qn_q;
	logic           out_vld_q;
	rmr_pkg::out_item_t out_q;

	// One restoring-division step shared by modulo and quotient passes
	logic [W:0]   trial;
	logic [W-1:0] rem_shift;
	logic         take;
	assign rem_shift = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial     = {rem_q[W-1], rem_shift} - {1'b0, b_q};
	assign take      = !trial[W];

	assign rready   = (state_q == ST_IDLE);
	assign empty    = !out_vld_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			// Result register: loaded from DONE, cleared by pop
			if (state_q == ST_DONE) out_vld_q <= 1'b1;
			else if (pop && out_vld_q) out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (rvalid) state_q <= ST_GCD;
				ST_GCD:  state_q <= (b_q == '0) ? ST_DIVN : ST_MOD;
				ST_MOD:  if (cnt_q == C'(W - 1)) state_q <= ST_GCD;
				ST_DIVN: if (a_q == '0 || cnt_q == C'(W - 1)) state_q <= ST_DIVD;
				ST_DIVD: if (a_q == '0 || cnt_q == C'(W - 1)) state_q <= ST_DONE;
				ST_DONE: if (!out_vld_q || pop) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: b_q is the divisor of the step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				nneg_q <= work.num_neg;
				dneg_q <= work.den_neg;
				nmag_q <= work.num_mag;
				dmag_q <= work.den_mag;
				a_q    <= work.num_mag;
				b_q    <= work.den_mag;
			end
			ST_GCD: begin
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
				if (b_q == '0) dvd_q <= nmag_q;
				else           dvd_q <= a_q;
				if (b_q == '0) b_q <= a_q;
			end
			ST_MOD, ST_DIVN, ST_DIVD: begin
				if (state_q == ST_DIVN && (a_q == '0 || cnt_q == C'(W - 1))) begin
					// numerator quotient done; set up the denominator pass
					qn_q  <= {quo_q[W-2:0], take};
					cnt_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
					dvd_q <= dmag_q;
				end else begin
					rem_q <= take ? trial[W-1:0] : rem_shift;
					quo_q <= {quo_q[W-2:0], take};
					dvd_q <= {dvd_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
				end
				if (state_q == ST_MOD && cnt_q == C'(W - 1)) begin
					a_q <= b_q;
					b_q <= take ? trial[W-1:0] : rem_shift;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || pop) begin
					if (a_q == '0) begin
						out_q.product_numerator   <= '0;
						out_q.product_denominator <= '0;
						out_q.zero_over_zero      <= 1'b1;
					end else begin
						out_q.product_numerator   <= nneg_q ? -{1'b0, qn_q} : {1'b0, qn_q};
						out_q.product_denominator <= dneg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
						out_q.zero_over_zero      <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

### hw/rtl/rational_multiply_reduce_core.sv
// Top level of the rational multiply-reduce block.
`timescale 1ns / 1ps
// Multiplies two signed fractions and reduces the product to lowest terms.
// Input channel: push/full with in_item; a transaction is taken when push is
// high and full is low. Result channel: empty/pop with out_item; the oldest
// result sits on out_item while empty is low and leaves when pop is high.
// A two-stage front end forms the products; a two-entry queue decouples it
// from the back end, which runs a Euclidean GCD by 63-step restoring
// remainder passes on one shared subtractor, then two 63-step divisions.
// The number of remainder passes depends on the operands; it is up to
// roughly 90 for 63-bit magnitudes.
// The back end reads the queue only while idle, so it takes no new item
// until the last one is through; the front end and the queue keep taking
// items meanwhile. When the receiver stalls the result is held, the back
// end finishes the next item and waits with it, then the queue and front
// end fill and full rises.
// Reset clears all valid state; no result is pending after reset.
// Zero over zero returns 0/0 with zero_over_zero set.
module rational_multiply_reduce_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  rmr_pkg::in_item_t   in_item,
	output logic                empty,
	input  logic                pop,
	output rmr_pkg::out_item_t  out_item
);
	logic           f_valid, f_ready, q_valid, q_ready;
	rmr_pkg::work_t f_work, q_work;

	rmr_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.wvalid(f_valid), .wready(f_ready), .work(f_work)
	);
	rmr_queue u_queue (
		.clk, .arst_n,
		.wvalid(f_valid), .wready(f_ready), .wdata(f_work),
		.rvalid(q_valid), .rready(q_ready), .rdata(q_work)
	);
	rmr_back u_back (
		.clk, .arst_n,
		.rvalid(q_valid), .rready(q_ready), .work(q_work),
		.empty, .pop, .out_item
	);
endmodule

### hw/rtl/rmr_checker.sv
// Port-level checker for the rational multiply-reduce block, with its bind.
`timescale 1ns / 1ps
module rmr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input rmr_pkg::out_item_t out_item
);
	// A held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(out_item)) else $error("result changed while held");
	// Zero over zero always reports 0/0
	a_zz: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.zero_over_zero |->
		out_item.product_numerator == '0 && out_item.product_denominator == '0)
		else $error("zero_over_zero without 0/0");
	// Reduced denominator is never zero unless numerator is a unit
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_item.zero_over_zero && out_item.product_denominator == '0 |->
		out_item.product_numerator == 64'sd1 || out_item.product_numerator == -64'sd1)
		else $error("n/0 not reduced");
	// No result right after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result after reset");
endmodule

bind rational_multiply_reduce_core rmr_checker u_rmr_checker (
	.clk, .arst_n, .empty, .pop, .out_item
);
